// ===== hw/rtl/snz_pkg.sv =====
// ----------------------------------------------------------------------------
// snz_pkg: shared types and constants for the simplex noise evaluator
// Item and result layouts, fixed-point widths, skew constants and the
// gradient and modulo-twelve helper functions.
// ----------------------------------------------------------------------------
package snz_pkg;

  localparam int TABLE_DEPTH     = 256;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int COORD_FRAC_BITS = 16;
  localparam int WORK_BITS       = 24;
  localparam int OFS_SHIFT       = 32 - WORK_BITS;

  localparam int CPOS_W = 65;
  localparam int CELL_W = CPOS_W - COORD_FRAC_BITS - 30;
  localparam int CS_W   = CELL_W + 2;
  localparam int U_W    = CS_W + 31;
  localparam int V_W    = U_W + 2;
  localparam int OFS_W  = 28;
  localparam int R2_W   = 2 * OFS_W + 2;
  localparam int T_W    = 36;
  localparam int D_W    = OFS_W + 2;
  localparam int TERM_W = WORK_BITS + 1 + D_W;
  localparam int SUM_W  = TERM_W + 2;
  localparam int SC_W   = SUM_W + 9;
  localparam int RND_W  = SC_W + 1;

  localparam int CORNERS    = 4;
  localparam int LOAD_STAGE = 6;
  localparam int PIPE_LAST  = 13;

  localparam logic signed [30:0] SKEW2_Q30   = 31'sd393016785;
  localparam logic signed [30:0] SKEW3_Q30   = 31'sd357913941;
  localparam logic signed [30:0] UNSKEW2_Q32 = 31'sd907633386;
  localparam logic signed [30:0] UNSKEW3_Q32 = 31'sd715827883;
  localparam logic signed [OFS_W-1:0] UNSKEW2_W = OFS_W'(3545443);
  localparam logic signed [OFS_W-1:0] UNSKEW3_W = OFS_W'(2796203);
  localparam logic signed [OFS_W-1:0] ONE_W     = OFS_W'(1 << WORK_BITS);
  localparam logic signed [T_W-1:0]   ATTEN2_W  = T_W'(8388608);
  localparam logic signed [T_W-1:0]   ATTEN3_W  = T_W'(10066330);
  localparam logic signed [8:0]       SCALE2    = 9'sd70;
  localparam logic signed [8:0]       SCALE3    = 9'sd32;

  localparam logic signed [1:0] GP = 2'sb01;
  localparam logic signed [1:0] GN = 2'sb11;
  localparam logic signed [1:0] GZ = 2'sb00;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_NOISE_2D = 2'd1,
    MODE_NOISE_3D = 2'd2
  } snz_mode_t;

  typedef struct packed {
    snz_mode_t          mode;
    logic [7:0]         table_index;
    logic [7:0]         table_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } snz_item_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               was_three_d;
  } snz_result_t;

  typedef struct packed {
    logic noise;
    logic load;
    logic three_d;
  } snz_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [7:0]       value;
    logic [3:0]       value_m12;
  } snz_load_t;

  typedef struct packed {
    logic             three_d;
    logic [IDX_W-1:0] ci;
    logic [IDX_W-1:0] cj;
    logic [IDX_W-1:0] ck;
  } snz_corner_t;

  typedef logic signed [1:0] snz_gcomp_t;
  typedef snz_gcomp_t [2:0] snz_grad_t;

  function automatic logic [3:0] mod_twelve(input logic [7:0] v);
    logic [15:0] q;
    logic [7:0]  r;
    q = 16'(v) * 16'd171;
    r = v - 8'(q[15:11]) * 8'd12;
    return r[3:0];
  endfunction

  function automatic snz_grad_t grad_dir(input logic [3:0] g);
    snz_grad_t r;
    unique case (g)
      4'd0:    r = {GZ, GP, GP};
      4'd1:    r = {GP, GZ, GP};
      4'd2:    r = {GP, GP, GZ};
      4'd3:    r = {GZ, GP, GN};
      4'd4:    r = {GP, GZ, GN};
      4'd5:    r = {GP, GN, GZ};
      4'd6:    r = {GZ, GN, GP};
      4'd7:    r = {GN, GZ, GP};
      4'd8:    r = {GN, GP, GZ};
      4'd9:    r = {GZ, GN, GN};
      4'd10:   r = {GN, GZ, GN};
      4'd11:   r = {GN, GN, GZ};
      default: r = {GZ, GZ, GZ};
    endcase
    return r;
  endfunction

  function automatic logic signed [D_W-1:0] dot_part(input snz_gcomp_t g,
                                                     input logic signed [OFS_W-1:0] v);
    logic signed [D_W-1:0] r;
    if (g == GP) begin
      r = D_W'(v);
    end else if (g == GN) begin
      r = -D_W'(v);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/snz_hash_lane.sv =====
// ----------------------------------------------------------------------------
// snz_hash_lane: corner hash through the permutation table
// Three chained table reads, each from its own copy of the table. Every copy
// is written by a load item in the same stage where it is read, so items see
// the table in the order they were accepted.
// ----------------------------------------------------------------------------
module snz_hash_lane
  import snz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  snz_load_t   ld,
  input  snz_corner_t corner,
  output logic [3:0]  grad_sel
);

  logic [7:0] perm_a [TABLE_DEPTH];
  logic [7:0] perm_b [TABLE_DEPTH];
  logic [3:0] perm_m12 [TABLE_DEPTH];

  logic             ld_v1;
  logic             ld_v2;
  logic [IDX_W-1:0] ld_idx1;
  logic [IDX_W-1:0] ld_idx2;
  logic [7:0]       ld_val1;
  logic [3:0]       ld_m12_1;
  logic [3:0]       ld_m12_2;
  logic             three_d1;
  logic             three_d2;
  logic [IDX_W-1:0] ci1;
  logic [IDX_W-1:0] ci2;
  logic [IDX_W-1:0] cj1;
  logic [7:0]       a1;
  logic [7:0]       a2;
  logic [7:0]       b2;
  logic [IDX_W-1:0] addr_a;
  logic [IDX_W-1:0] addr_b;
  logic [IDX_W-1:0] addr_c;

  assign addr_a = corner.three_d ? corner.ck : corner.cj;
  assign addr_b = cj1 + IDX_W'(a1);
  assign addr_c = ci2 + IDX_W'(three_d2 ? b2 : a2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_v1 <= 1'b0;
      ld_v2 <= 1'b0;
    end else if (en) begin
      ld_v1 <= ld.valid;
      ld_v2 <= ld_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld.valid) begin
        perm_a[ld.idx] <= ld.value;
      end
      a1       <= perm_a[addr_a];
      ld_idx1  <= ld.idx;
      ld_val1  <= ld.value;
      ld_m12_1 <= ld.value_m12;
      three_d1 <= corner.three_d;
      ci1      <= corner.ci;
      cj1      <= corner.cj;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_v1) begin
        perm_b[ld_idx1] <= ld_val1;
      end
      b2       <= perm_b[addr_b];
      a2       <= a1;
      ld_idx2  <= ld_idx1;
      ld_m12_2 <= ld_m12_1;
      three_d2 <= three_d1;
      ci2      <= ci1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ld_v2) begin
        perm_m12[ld_idx2] <= ld_m12_2;
      end
      grad_sel <= perm_m12[addr_c];
    end
  end

endmodule

// ===== hw/rtl/simplex_noise_2d_3d.sv =====
// ----------------------------------------------------------------------------
// simplex_noise_2d_3d: pipelined 2D/3D simplex noise in fixed point
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    item   (snz_item_t)
//   result   result_valid / result_stall result (snz_result_t)
//
// One item enters per cycle unless a held result stalls; a noise result
// appears after its item has passed the fourteen register stages of the datapath.
// Load items update the three table copies in each of the four hash lanes
// in item order and give no result. Reset clears the valid bits only; table
// entries stay undefined until loaded. A held result stalls the whole
// pipeline, and item_stall follows it in the same cycle.
// ----------------------------------------------------------------------------
module simplex_noise_2d_3d
  import snz_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  snz_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output snz_result_t result
);

  logic     adv;
  logic     accept;
  snz_ctl_t ctl_in;
  snz_ctl_t ctl [1:PIPE_LAST];

  logic [IDX_W-1:0] ld_idx [1:LOAD_STAGE];
  logic [7:0]       ld_val [1:LOAD_STAGE];
  logic [3:0]       ld_m12 [1:LOAD_STAGE];

  logic signed [31:0]     zsel;
  logic signed [31:0]     crd [1:4][3];
  logic signed [33:0]     sum1;
  logic signed [CPOS_W-1:0] s2;
  logic signed [CPOS_W-1:0] cpos [3];
  logic signed [CELL_W-1:0] cell3 [3];
  logic signed [CELL_W-1:0] cell4 [3];
  logic signed [CS_W-1:0]   cs;
  logic signed [U_W-1:0]    u4;
  logic signed [V_W-1:0]    vofs [3];
  logic signed [OFS_W-1:0]  ofs5 [3];
  logic [IDX_W-1:0]         hidx5 [3];

  logic [2:0]               b1;
  logic [2:0]               b2;
  logic [2:0]               cb [CORNERS];
  logic signed [OFS_W-1:0]  bias [CORNERS];
  logic signed [OFS_W-1:0]  cofs_next [CORNERS][3];
  logic [IDX_W-1:0]         cidx_next [CORNERS][3];
  logic signed [OFS_W-1:0]  cofs [6:9][CORNERS][3];
  logic [IDX_W-1:0]         cidx6 [CORNERS][3];

  snz_load_t                lane_ld;
  snz_corner_t              lane_corner [CORNERS];
  logic [3:0]               g9 [CORNERS];

  logic signed [R2_W-1:0]   r2_next [CORNERS];
  logic signed [R2_W-1:0]   r2_7 [CORNERS];
  logic signed [T_W-1:0]    t_full [CORNERS];
  logic [WORK_BITS-1:0]     t8 [CORNERS];
  logic [2*WORK_BITS-1:0]   tsq [CORNERS];
  logic [WORK_BITS-1:0]     t2_9 [CORNERS];
  logic [2*WORK_BITS-1:0]   t2sq [CORNERS];
  logic [WORK_BITS-1:0]     t4_10 [CORNERS];
  snz_grad_t                gr [CORNERS];
  logic signed [D_W-1:0]    d_next [CORNERS];
  logic signed [D_W-1:0]    d10 [CORNERS];
  logic signed [TERM_W-1:0] term11 [CORNERS];
  logic signed [SUM_W-1:0]  sum12;
  logic signed [SC_W-1:0]   sc13;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  shv;
  logic signed [15:0]       sat;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;
  assign accept     = item_valid && adv;

  always_comb begin
    ctl_in.noise   = accept && (item.mode == MODE_NOISE_2D || item.mode == MODE_NOISE_3D);
    ctl_in.load    = accept && (item.mode == MODE_LOAD);
    ctl_in.three_d = (item.mode == MODE_NOISE_3D);
    zsel           = (item.mode == MODE_NOISE_3D) ? item.coord_z : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 1; n <= PIPE_LAST; n++) begin
        ctl[n] <= '0;
      end
      result_valid <= 1'b0;
    end else if (adv) begin
      ctl[1] <= ctl_in;
      for (int n = 2; n <= PIPE_LAST; n++) begin
        ctl[n] <= ctl[n-1];
      end
      result_valid <= ctl[PIPE_LAST].noise;
    end
  end

  // Skew, cell index and unskewed offsets.
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      cpos[d] = (CPOS_W'(crd[2][d]) <<< 30) + s2;
    end
    cs = CS_W'(cell3[0]) + CS_W'(cell3[1]) + CS_W'(cell3[2]);
    for (int d = 0; d < 3; d++) begin
      vofs[d] = (V_W'(crd[4][d]) <<< (32 - COORD_FRAC_BITS)) - (V_W'(cell4[d]) <<< 32)
                + V_W'(u4);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ld_idx[1] <= item.table_index[IDX_W-1:0];
      ld_val[1] <= item.table_value;
      ld_m12[1] <= mod_twelve(item.table_value);
      for (int n = 2; n <= LOAD_STAGE; n++) begin
        ld_idx[n] <= ld_idx[n-1];
        ld_val[n] <= ld_val[n-1];
        ld_m12[n] <= ld_m12[n-1];
      end
      crd[1][0] <= item.coord_x;
      crd[1][1] <= item.coord_y;
      crd[1][2] <= zsel;
      for (int n = 2; n <= 4; n++) begin
        crd[n] <= crd[n-1];
      end
      sum1 <= 34'($signed(item.coord_x)) + 34'($signed(item.coord_y)) + 34'(zsel);
      s2   <= sum1 * (ctl[1].three_d ? SKEW3_Q30 : SKEW2_Q30);
      for (int d = 0; d < 3; d++) begin
        cell3[d] <= (d == 2 && !ctl[2].three_d) ? '0 : cpos[d][CPOS_W-1 -: CELL_W];
      end
      cell4 <= cell3;
      u4    <= cs * (ctl[3].three_d ? UNSKEW3_Q32 : UNSKEW2_Q32);
      for (int d = 0; d < 3; d++) begin
        ofs5[d]  <= vofs[d][OFS_SHIFT +: OFS_W];
        hidx5[d] <= cell4[d][IDX_W-1:0];
      end
    end
  end

  // Simplex order and corner offsets.
  always_comb begin
    if (ctl[5].three_d) begin
      if (ofs5[0] >= ofs5[1]) begin
        if (ofs5[1] >= ofs5[2]) begin
          b1 = 3'b001;
          b2 = 3'b011;
        end else if (ofs5[0] >= ofs5[2]) begin
          b1 = 3'b001;
          b2 = 3'b101;
        end else begin
          b1 = 3'b100;
          b2 = 3'b101;
        end
      end else begin
        if (ofs5[1] < ofs5[2]) begin
          b1 = 3'b100;
          b2 = 3'b110;
        end else if (ofs5[0] < ofs5[2]) begin
          b1 = 3'b010;
          b2 = 3'b110;
        end else begin
          b1 = 3'b010;
          b2 = 3'b011;
        end
      end
    end else begin
      b1 = (ofs5[0] > ofs5[1]) ? 3'b001 : 3'b010;
      b2 = 3'b011;
    end
    cb[0] = 3'b000;
    cb[1] = b1;
    cb[2] = b2;
    cb[3] = 3'b111;
    for (int n = 0; n < CORNERS; n++) begin
      bias[n] = OFS_W'(n) * (ctl[5].three_d ? UNSKEW3_W : UNSKEW2_W);
      for (int d = 0; d < 3; d++) begin
        if (d == 2 && !ctl[5].three_d) begin
          cofs_next[n][d] = '0;
        end else begin
          cofs_next[n][d] = ofs5[d] - (cb[n][d] ? ONE_W : '0) + bias[n];
        end
        cidx_next[n][d] = hidx5[d] + IDX_W'(cb[n][d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cofs[6] <= cofs_next;
      cidx6   <= cidx_next;
      for (int n = 7; n <= 9; n++) begin
        cofs[n] <= cofs[n-1];
      end
    end
  end

  always_comb begin
    lane_ld.valid     = ctl[LOAD_STAGE].load;
    lane_ld.idx       = ld_idx[LOAD_STAGE];
    lane_ld.value     = ld_val[LOAD_STAGE];
    lane_ld.value_m12 = ld_m12[LOAD_STAGE];
    for (int n = 0; n < CORNERS; n++) begin
      lane_corner[n].three_d = ctl[6].three_d;
      lane_corner[n].ci      = cidx6[n][0];
      lane_corner[n].cj      = cidx6[n][1];
      lane_corner[n].ck      = cidx6[n][2];
    end
  end

  for (genvar n = 0; n < CORNERS; n++) begin : g_lane
    snz_hash_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ld       (lane_ld),
      .corner   (lane_corner[n]),
      .grad_sel (g9[n])
    );
  end

  // Corner falloff, gradient dot product and final scaling.
  always_comb begin
    for (int n = 0; n < CORNERS; n++) begin
      r2_next[n] = '0;
      for (int d = 0; d < 3; d++) begin
        r2_next[n] = r2_next[n] + R2_W'(cofs[6][n][d]) * R2_W'(cofs[6][n][d]);
      end
      t_full[n] = (ctl[7].three_d ? ATTEN3_W : ATTEN2_W) - T_W'(r2_7[n] >>> WORK_BITS);
      tsq[n]    = t8[n] * t8[n];
      t2sq[n]   = t2_9[n] * t2_9[n];
      gr[n]     = grad_dir(g9[n]);
      d_next[n] = '0;
      for (int d = 0; d < 3; d++) begin
        d_next[n] = d_next[n] + dot_part(gr[n][d], cofs[9][n][d]);
      end
    end
    rnd = RND_W'(sc13) + (RND_W'(1) <<< 32);
    shv = rnd >>> 33;
    if (shv > RND_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (shv < -RND_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = shv[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < CORNERS; n++) begin
        r2_7[n] <= r2_next[n];
        if (t_full[n] < 0 || (n == CORNERS - 1 && !ctl[7].three_d)) begin
          t8[n] <= '0;
        end else begin
          t8[n] <= t_full[n][WORK_BITS-1:0];
        end
        t2_9[n]   <= tsq[n][2*WORK_BITS-1 -: WORK_BITS];
        t4_10[n]  <= t2sq[n][2*WORK_BITS-1 -: WORK_BITS];
        d10[n]    <= d_next[n];
        term11[n] <= $signed({1'b0, t4_10[n]}) * d10[n];
      end
      sum12 <= SUM_W'(term11[0]) + SUM_W'(term11[1]) + SUM_W'(term11[2]) + SUM_W'(term11[3]);
      sc13  <= sum12 * (ctl[12].three_d ? SCALE3 : SCALE2);
      result.noise_value <= sat;
      result.was_three_d <= ctl[PIPE_LAST].three_d;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(ctl[PIPE_LAST]))
    else $error("pipeline moved while the result was held");

  a_corner3_2d: assert property (@(posedge clk) disable iff (rst)
    (ctl[8].noise && !ctl[8].three_d) |-> (t8[CORNERS-1] == '0))
    else $error("fourth corner contributes to a 2D item");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(ctl[PIPE_LAST].noise))
    else $error("result without a noise item at the last stage");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled while the output could move");

endmodule
